// ===== rtl/core/oidc_pkg.sv =====
// oidc_pkg: shared codes, reset values and status type for the drive control core
// no dependencies
`default_nettype none

package oidc_pkg;

   localparam int unsigned CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESSURE_LIMIT     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISTANCE_LIMIT     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_FAST_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_SLOW_WIDTH   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEER_CENTER_WIDTH = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEER_RIGHT_WIDTH  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEER_LEFT_WIDTH   = 3'd6;

   localparam logic [31:0] PRESSURE_LIMIT_RST     = 32'd600;
   localparam logic [31:0] DISTANCE_LIMIT_RST     = 32'd5;
   localparam logic [31:0] SPEED_FAST_WIDTH_RST   = 32'd65534;
   localparam logic [31:0] SPEED_SLOW_WIDTH_RST   = 32'd4095;
   localparam logic [31:0] STEER_CENTER_WIDTH_RST = 32'd1350;
   localparam logic [31:0] STEER_RIGHT_WIDTH_RST  = 32'd700;
   localparam logic [31:0] STEER_LEFT_WIDTH_RST   = 32'd2300;

   localparam logic [1:0] POL_DEFAULT = 2'd0;
   localparam logic [1:0] POL_FWD     = 2'd1;
   localparam logic [1:0] POL_BWD     = 2'd2;
   localparam logic [1:0] POL_STOP    = 2'd3;

   localparam logic [1:0] DIR_FWD  = 2'd0;
   localparam logic [1:0] DIR_BWD  = 2'd1;
   localparam logic [1:0] DIR_STOP = 2'd2;

   localparam logic [7:0] CMD_FWD_CENTER = 8'h77; // w
   localparam logic [7:0] CMD_FWD_LEFT   = 8'h71; // q
   localparam logic [7:0] CMD_FWD_RIGHT  = 8'h65; // e
   localparam logic [7:0] CMD_BWD_CENTER = 8'h73; // s
   localparam logic [7:0] CMD_BWD_LEFT   = 8'h61; // a
   localparam logic [7:0] CMD_BWD_RIGHT  = 8'h64; // d
   localparam logic [7:0] CMD_STOP       = 8'h70; // p
   localparam logic [7:0] CMD_FAST       = 8'h6d; // m
   localparam logic [7:0] CMD_SLOW       = 8'h6e; // n

   typedef struct packed {
      logic [1:0] policy;
      logic [1:0] drive_dir;
      logic       buzzer_on;
      logic       announce;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/oidc_channels.sv =====
// oidc_req_if / oidc_rsp_if: valid-ready channels for control ticks and drive results
// no dependencies
`default_nettype none

interface oidc_req_if #(
   parameter int unsigned PRESSURE_BITS = 12,
   parameter int unsigned ECHO_BITS     = 16
);
   logic                     valid;
   logic                     ready;
   logic [PRESSURE_BITS-1:0] pressure_sample;
   logic [ECHO_BITS-1:0]     front_echo;
   logic [ECHO_BITS-1:0]     rear_echo;
   logic [7:0]               cmd;

   modport source (output valid, pressure_sample, front_echo, rear_echo, cmd, input ready);
   modport sink   (input valid, pressure_sample, front_echo, rear_echo, cmd, output ready);
endinterface

interface oidc_rsp_if #(
   parameter int unsigned PULSE_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            policy;
   logic [1:0]            drive_dir;
   logic [PULSE_BITS-1:0] steer_width;
   logic [PULSE_BITS-1:0] speed_width;
   logic                  buzzer_on;
   logic                  announce;

   modport source (output valid, policy, drive_dir, steer_width, speed_width, buzzer_on,
                   announce, input ready);
   modport sink   (input valid, policy, drive_dir, steer_width, speed_width, buzzer_on,
                   announce, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/oidc_csr.sv =====
// oidc_csr: configuration register file with write-only plain port
// depends on oidc_pkg
`default_nettype none

module oidc_csr #(
   parameter int unsigned PRESSURE_BITS = 12,
   parameter int unsigned ECHO_BITS     = 16,
   parameter int unsigned PULSE_BITS    = 16,
   parameter int unsigned CSR_BITS      = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wen,
   input  wire logic [oidc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_BITS-1:0]                 csr_wdata,
   output logic [PRESSURE_BITS-1:0]                 pressure_limit,
   output logic [ECHO_BITS-1:0]                     distance_limit,
   output logic [PULSE_BITS-1:0]                    speed_fast_width,
   output logic [PULSE_BITS-1:0]                    speed_slow_width,
   output logic [PULSE_BITS-1:0]                    steer_center_width,
   output logic [PULSE_BITS-1:0]                    steer_right_width,
   output logic [PULSE_BITS-1:0]                    steer_left_width
);

   logic [PRESSURE_BITS-1:0] pressure_thr_ff;
   logic [ECHO_BITS-1:0]     distance_thr_ff;
   logic [PULSE_BITS-1:0]    speed_fast_ff;
   logic [PULSE_BITS-1:0]    speed_slow_ff;
   logic [PULSE_BITS-1:0]    steer_center_ff;
   logic [PULSE_BITS-1:0]    steer_right_ff;
   logic [PULSE_BITS-1:0]    steer_left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pressure_thr_ff <= oidc_pkg::PRESSURE_LIMIT_RST[PRESSURE_BITS-1:0];
         distance_thr_ff <= oidc_pkg::DISTANCE_LIMIT_RST[ECHO_BITS-1:0];
         speed_fast_ff   <= oidc_pkg::SPEED_FAST_WIDTH_RST[PULSE_BITS-1:0];
         speed_slow_ff   <= oidc_pkg::SPEED_SLOW_WIDTH_RST[PULSE_BITS-1:0];
         steer_center_ff <= oidc_pkg::STEER_CENTER_WIDTH_RST[PULSE_BITS-1:0];
         steer_right_ff  <= oidc_pkg::STEER_RIGHT_WIDTH_RST[PULSE_BITS-1:0];
         steer_left_ff   <= oidc_pkg::STEER_LEFT_WIDTH_RST[PULSE_BITS-1:0];
      end else if (csr_wen) begin
         unique case (csr_index)
            oidc_pkg::CSR_PRESSURE_LIMIT:     pressure_thr_ff <= csr_wdata[PRESSURE_BITS-1:0];
            oidc_pkg::CSR_DISTANCE_LIMIT:     distance_thr_ff <= csr_wdata[ECHO_BITS-1:0];
            oidc_pkg::CSR_SPEED_FAST_WIDTH:   speed_fast_ff   <= csr_wdata[PULSE_BITS-1:0];
            oidc_pkg::CSR_SPEED_SLOW_WIDTH:   speed_slow_ff   <= csr_wdata[PULSE_BITS-1:0];
            oidc_pkg::CSR_STEER_CENTER_WIDTH: steer_center_ff <= csr_wdata[PULSE_BITS-1:0];
            oidc_pkg::CSR_STEER_RIGHT_WIDTH:  steer_right_ff  <= csr_wdata[PULSE_BITS-1:0];
            oidc_pkg::CSR_STEER_LEFT_WIDTH:   steer_left_ff   <= csr_wdata[PULSE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign pressure_limit     = pressure_thr_ff;
   assign distance_limit     = distance_thr_ff;
   assign speed_fast_width   = speed_fast_ff;
   assign speed_slow_width   = speed_slow_ff;
   assign steer_center_width = steer_center_ff;
   assign steer_right_width  = steer_right_ff;
   assign steer_left_width   = steer_left_ff;

endmodule

`default_nettype wire

// ===== rtl/core/oidc_step.sv =====
// oidc_step: per-tick policy decision, interlock and command decode
// depends on oidc_pkg
`default_nettype none

module oidc_step #(
   parameter int unsigned PRESSURE_BITS = 12,
   parameter int unsigned ECHO_BITS     = 16,
   parameter int unsigned PULSE_BITS    = 16
) (
   input  wire logic [PRESSURE_BITS-1:0] pressure_sample,
   input  wire logic [ECHO_BITS-1:0]     front_echo,
   input  wire logic [ECHO_BITS-1:0]     rear_echo,
   input  wire logic [7:0]               cmd,
   input  wire logic [PRESSURE_BITS-1:0] pressure_limit,
   input  wire logic [ECHO_BITS-1:0]     distance_limit,
   input  wire logic [PULSE_BITS-1:0]    speed_fast_width,
   input  wire logic [PULSE_BITS-1:0]    speed_slow_width,
   input  wire logic [PULSE_BITS-1:0]    steer_center_width,
   input  wire logic [PULSE_BITS-1:0]    steer_right_width,
   input  wire logic [PULSE_BITS-1:0]    steer_left_width,
   input  wire logic [1:0]               prev_policy,
   input  wire logic [1:0]               drive_cur,
   input  wire logic [PULSE_BITS-1:0]    steer_cur,
   input  wire logic [PULSE_BITS-1:0]    speed_cur,
   output oidc_pkg::status_type          status,
   output logic [PULSE_BITS-1:0]         steer_next,
   output logic [PULSE_BITS-1:0]         speed_next
);

   logic       front_close;
   logic       rear_close;
   logic [1:0] policy;
   logic [1:0] drive_mid;
   logic [1:0] drive_next;
   logic       fwd_ok;
   logic       bwd_ok;

   assign front_close = front_echo < distance_limit;
   assign rear_close  = rear_echo < distance_limit;

   always_comb begin
      policy = oidc_pkg::POL_DEFAULT;
      if (pressure_sample > pressure_limit) begin
         priority if (front_close && rear_close) policy = oidc_pkg::POL_STOP;
         else if (front_close) policy = oidc_pkg::POL_BWD;
         else if (rear_close) policy = oidc_pkg::POL_FWD;
         else policy = oidc_pkg::POL_DEFAULT;
      end
   end

   // interlock against the current direction
   always_comb begin
      drive_mid = drive_cur;
      if (policy == oidc_pkg::POL_STOP ||
          (policy == oidc_pkg::POL_FWD && drive_cur == oidc_pkg::DIR_BWD) ||
          (policy == oidc_pkg::POL_BWD && drive_cur == oidc_pkg::DIR_FWD)) begin
         drive_mid = oidc_pkg::DIR_STOP;
      end
   end

   assign fwd_ok = (policy == oidc_pkg::POL_DEFAULT) || (policy == oidc_pkg::POL_FWD);
   assign bwd_ok = (policy == oidc_pkg::POL_DEFAULT) || (policy == oidc_pkg::POL_BWD);

   always_comb begin
      drive_next = drive_mid;
      steer_next = steer_cur;
      speed_next = speed_cur;
      unique case (cmd)
         oidc_pkg::CMD_FWD_CENTER: if (fwd_ok) begin
            drive_next = oidc_pkg::DIR_FWD;
            steer_next = steer_center_width;
         end
         oidc_pkg::CMD_FWD_LEFT: if (fwd_ok) begin
            drive_next = oidc_pkg::DIR_FWD;
            steer_next = steer_left_width;
         end
         oidc_pkg::CMD_FWD_RIGHT: if (fwd_ok) begin
            drive_next = oidc_pkg::DIR_FWD;
            steer_next = steer_right_width;
         end
         oidc_pkg::CMD_BWD_CENTER: if (bwd_ok) begin
            drive_next = oidc_pkg::DIR_BWD;
            steer_next = steer_center_width;
         end
         oidc_pkg::CMD_BWD_LEFT: if (bwd_ok) begin
            drive_next = oidc_pkg::DIR_BWD;
            steer_next = steer_left_width;
         end
         oidc_pkg::CMD_BWD_RIGHT: if (bwd_ok) begin
            drive_next = oidc_pkg::DIR_BWD;
            steer_next = steer_right_width;
         end
         oidc_pkg::CMD_STOP: drive_next = oidc_pkg::DIR_STOP;
         oidc_pkg::CMD_FAST: speed_next = speed_fast_width;
         oidc_pkg::CMD_SLOW: speed_next = speed_slow_width;
         default: begin
         end
      endcase
   end

   assign status.policy    = policy;
   assign status.drive_dir = drive_next;
   assign status.buzzer_on = policy != oidc_pkg::POL_DEFAULT;
   assign status.announce  = (policy != prev_policy) && (policy != oidc_pkg::POL_DEFAULT);

endmodule

`default_nettype wire

// ===== rtl/core/obstacle_interlocked_drive_control_core.sv =====
// obstacle_interlocked_drive_control_core: top level of the drive control core
// depends on oidc_pkg, oidc_channels, oidc_csr, oidc_step
// a tick is held in the input register, then its result in the result register
// throughput: one tick per cycle through the single-pass step logic between the
// input and result registers, while the result side does not stall it
// reset: synchronous; clears both stages, loads register and drive state reset values
`default_nettype none

module obstacle_interlocked_drive_control_core #(
   parameter int unsigned PRESSURE_BITS = 12,
   parameter int unsigned ECHO_BITS     = 16,
   parameter int unsigned PULSE_BITS    = 16,
   localparam int unsigned WIDE_BITS    = (ECHO_BITS > PULSE_BITS) ? ECHO_BITS : PULSE_BITS,
   localparam int unsigned CSR_BITS     = (PRESSURE_BITS > WIDE_BITS) ? PRESSURE_BITS : WIDE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   oidc_req_if.sink                                 req_chan,
   oidc_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_wen,
   input  wire logic [oidc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_BITS-1:0]                 csr_wdata
);

   logic [PRESSURE_BITS-1:0] pressure_limit;
   logic [ECHO_BITS-1:0]     distance_limit;
   logic [PULSE_BITS-1:0]    speed_fast_width;
   logic [PULSE_BITS-1:0]    speed_slow_width;
   logic [PULSE_BITS-1:0]    steer_center_width;
   logic [PULSE_BITS-1:0]    steer_right_width;
   logic [PULSE_BITS-1:0]    steer_left_width;

   oidc_csr #(
      .PRESSURE_BITS(PRESSURE_BITS),
      .ECHO_BITS    (ECHO_BITS),
      .PULSE_BITS   (PULSE_BITS),
      .CSR_BITS     (CSR_BITS)
   ) u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .pressure_limit    (pressure_limit),
      .distance_limit    (distance_limit),
      .speed_fast_width  (speed_fast_width),
      .speed_slow_width  (speed_slow_width),
      .steer_center_width(steer_center_width),
      .steer_right_width (steer_right_width),
      .steer_left_width  (steer_left_width)
   );

   // input stage
   logic                     in_valid_ff;
   logic [PRESSURE_BITS-1:0] pressure_ff;
   logic [ECHO_BITS-1:0]     front_ff;
   logic [ECHO_BITS-1:0]     rear_ff;
   logic [7:0]               cmd_ff;

   // result stage
   logic                     out_valid_ff;
   oidc_pkg::status_type     status_ff;
   logic [PULSE_BITS-1:0]    steer_out_ff;
   logic [PULSE_BITS-1:0]    speed_out_ff;

   // drive state
   logic [1:0]               prev_policy_ff;
   logic [1:0]               drive_ff;
   logic [PULSE_BITS-1:0]    steer_ff;
   logic [PULSE_BITS-1:0]    speed_ff;

   oidc_pkg::status_type     status_in;
   logic [PULSE_BITS-1:0]    steer_in;
   logic [PULSE_BITS-1:0]    speed_in;

   logic out_free;
   logic advance;
   logic req_take;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_chan.ready = !reset && (!in_valid_ff || advance);
   assign req_take = req_chan.valid && req_chan.ready;

   oidc_step #(
      .PRESSURE_BITS(PRESSURE_BITS),
      .ECHO_BITS    (ECHO_BITS),
      .PULSE_BITS   (PULSE_BITS)
   ) u_step (
      .pressure_sample   (pressure_ff),
      .front_echo        (front_ff),
      .rear_echo         (rear_ff),
      .cmd               (cmd_ff),
      .pressure_limit    (pressure_limit),
      .distance_limit    (distance_limit),
      .speed_fast_width  (speed_fast_width),
      .speed_slow_width  (speed_slow_width),
      .steer_center_width(steer_center_width),
      .steer_right_width (steer_right_width),
      .steer_left_width  (steer_left_width),
      .prev_policy       (prev_policy_ff),
      .drive_cur         (drive_ff),
      .steer_cur         (steer_ff),
      .speed_cur         (speed_ff),
      .status            (status_in),
      .steer_next        (steer_in),
      .speed_next        (speed_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pressure_ff <= req_chan.pressure_sample;
         front_ff    <= req_chan.front_echo;
         rear_ff     <= req_chan.rear_echo;
         cmd_ff      <= req_chan.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         prev_policy_ff <= oidc_pkg::POL_DEFAULT;
         drive_ff       <= oidc_pkg::DIR_STOP;
         steer_ff       <= oidc_pkg::STEER_CENTER_WIDTH_RST[PULSE_BITS-1:0];
         speed_ff       <= oidc_pkg::SPEED_FAST_WIDTH_RST[PULSE_BITS-1:0];
      end else if (advance) begin
         out_valid_ff   <= 1'b1;
         prev_policy_ff <= status_in.policy;
         drive_ff       <= status_in.drive_dir;
         steer_ff       <= steer_in;
         speed_ff       <= speed_in;
      end else if (rsp_chan.ready) begin
         out_valid_ff   <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff    <= status_in;
         steer_out_ff <= steer_in;
         speed_out_ff <= speed_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.policy      = status_ff.policy;
   assign rsp_chan.drive_dir   = status_ff.drive_dir;
   assign rsp_chan.steer_width = steer_out_ff;
   assign rsp_chan.speed_width = speed_out_ff;
   assign rsp_chan.buzzer_on   = status_ff.buzzer_on;
   assign rsp_chan.announce    = status_ff.announce;

   a_stop_policy_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.policy == oidc_pkg::POL_STOP)
         |-> rsp_chan.drive_dir == oidc_pkg::DIR_STOP)
      else $error("stop policy with drive not stopped");

   a_announce_needs_buzzer: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.announce) |-> rsp_chan.buzzer_on)
      else $error("announce without buzzer");

   a_drive_code_legal: assert property (@(posedge clock) disable iff (reset)
      drive_ff <= oidc_pkg::DIR_STOP)
      else $error("illegal drive state");

   a_full_stage_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |-> !req_chan.ready)
      else $error("input accepted while input stage is stalled");

   a_result_follows_tick: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff && drive_ff == $past(status_in.drive_dir))
      else $error("drive state not updated with result");

endmodule

`default_nettype wire

// ===== tb/obstacle_interlocked_drive_control_core_tb.sv =====
// obstacle_interlocked_drive_control_core_tb: self-checking bench for the drive control core
// sends control ticks and register writes, predicts or pins each drive result and compares it
// depends on oidc_pkg, oidc_channels and obstacle_interlocked_drive_control_core

module obstacle_interlocked_drive_control_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CSR_BITS = 16;
   localparam logic [oidc_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;

   localparam logic [7:0] CMD_NONE     = 8'h00;
   localparam logic [7:0] CMD_ODD_LOW  = 8'h01;
   localparam logic [7:0] CMD_UPPER_W  = 8'h57;
   localparam logic [7:0] CMD_HIGH_BIT = 8'h80;
   localparam logic [7:0] CMD_ALL_ONES = 8'hff;

   localparam logic [8:0][7:0] DRIVE_CMDS = {
      oidc_pkg::CMD_FWD_CENTER, oidc_pkg::CMD_FWD_LEFT, oidc_pkg::CMD_FWD_RIGHT,
      oidc_pkg::CMD_BWD_CENTER, oidc_pkg::CMD_BWD_LEFT, oidc_pkg::CMD_BWD_RIGHT,
      oidc_pkg::CMD_STOP, oidc_pkg::CMD_FAST, oidc_pkg::CMD_SLOW};

   localparam logic [15:0] CENTER_RST = oidc_pkg::STEER_CENTER_WIDTH_RST[15:0];
   localparam logic [15:0] FAST_RST   = oidc_pkg::SPEED_FAST_WIDTH_RST[15:0];

   localparam int PHASES      = 8;
   localparam int PHASE_TICKS = 180;
   localparam int HOLD_CYCLES = 64;
   localparam int LIMIT_NS    = 8_000_000;

   typedef struct packed {
      logic [11:0] pressure;
      logic [15:0] front;
      logic [15:0] rear;
      logic [7:0]  cmd;
   } tick_type;

   typedef struct packed {
      logic [1:0]  policy;
      logic [1:0]  drive_dir;
      logic [15:0] steer_width;
      logic [15:0] speed_width;
      logic        buzzer_on;
      logic        announce;
   } drive_result_type;

   typedef struct packed {
      tick_type         t;
      bit               pinned;
      drive_result_type want;
   } stim_row_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_wen;
   logic [oidc_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0]                 csr_wdata;

   oidc_req_if req_bus ();
   oidc_rsp_if rsp_bus ();

   obstacle_interlocked_drive_control_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the register file
   logic [11:0] lim_pressure;
   logic [15:0] lim_distance;
   logic [15:0] w_fast, w_slow, w_center, w_right, w_left;

   // predicted drive state
   logic [1:0]  pol_last;
   logic [1:0]  dir_now;
   logic [15:0] steer_now;
   logic [15:0] speed_now;

   drive_result_type pending_results[$];
   stim_row_type     stim_rows[$];
   int               mismatches = 0;
   bit               quiet = 1'b0;
   bit               hold_req = 1'b0;
   bit               pin_on;
   drive_result_type pin_want;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      mismatches++;
   endtask

   function automatic void steer_to(logic [1:0] dir, logic [15:0] width, logic [1:0] pol);
      if (!(pol == oidc_pkg::POL_STOP ||
            (dir == oidc_pkg::DIR_FWD && pol == oidc_pkg::POL_BWD) ||
            (dir == oidc_pkg::DIR_BWD && pol == oidc_pkg::POL_FWD))) begin
         steer_now = width;
         dir_now   = dir;
      end
   endfunction

   function automatic drive_result_type advance_drive(tick_type t);
      drive_result_type r;
      logic [1:0]       pol;
      logic             near_front;
      logic             near_rear;
      pol        = oidc_pkg::POL_DEFAULT;
      near_front = t.front < lim_distance;
      near_rear  = t.rear < lim_distance;
      if (t.pressure > lim_pressure) begin
         if (near_front && near_rear) pol = oidc_pkg::POL_STOP;
         else if (near_front) pol = oidc_pkg::POL_BWD;
         else if (near_rear) pol = oidc_pkg::POL_FWD;
      end
      if (pol == oidc_pkg::POL_STOP ||
          (pol == oidc_pkg::POL_FWD && dir_now == oidc_pkg::DIR_BWD) ||
          (pol == oidc_pkg::POL_BWD && dir_now == oidc_pkg::DIR_FWD)) begin
         dir_now = oidc_pkg::DIR_STOP;
      end
      r.announce = (pol != pol_last) && (pol != oidc_pkg::POL_DEFAULT);
      pol_last   = pol;
      case (t.cmd)
         oidc_pkg::CMD_FWD_CENTER: steer_to(oidc_pkg::DIR_FWD, w_center, pol);
         oidc_pkg::CMD_FWD_LEFT:   steer_to(oidc_pkg::DIR_FWD, w_left, pol);
         oidc_pkg::CMD_FWD_RIGHT:  steer_to(oidc_pkg::DIR_FWD, w_right, pol);
         oidc_pkg::CMD_BWD_CENTER: steer_to(oidc_pkg::DIR_BWD, w_center, pol);
         oidc_pkg::CMD_BWD_LEFT:   steer_to(oidc_pkg::DIR_BWD, w_left, pol);
         oidc_pkg::CMD_BWD_RIGHT:  steer_to(oidc_pkg::DIR_BWD, w_right, pol);
         oidc_pkg::CMD_STOP:       dir_now = oidc_pkg::DIR_STOP;
         oidc_pkg::CMD_FAST:       speed_now = w_fast;
         oidc_pkg::CMD_SLOW:       speed_now = w_slow;
         default: ;
      endcase
      r.policy      = pol;
      r.drive_dir   = dir_now;
      r.steer_width = steer_now;
      r.speed_width = speed_now;
      r.buzzer_on   = (pol != oidc_pkg::POL_DEFAULT);
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      tick_type         t;
      drive_result_type got;
      drive_result_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.policy      = rsp_bus.policy;
            got.drive_dir   = rsp_bus.drive_dir;
            got.steer_width = rsp_bus.steer_width;
            got.speed_width = rsp_bus.speed_width;
            got.buzzer_on   = rsp_bus.buzzer_on;
            got.announce    = rsp_bus.announce;
            if (pending_results.size() == 0) begin
               report_mismatch("result with none pending, policy", got.policy, 0);
            end else begin
               want = pending_results.pop_front();
               if (got.policy !== want.policy)
                  report_mismatch("policy", got.policy, want.policy);
               if (got.drive_dir !== want.drive_dir)
                  report_mismatch("drive_dir", got.drive_dir, want.drive_dir);
               if (got.steer_width !== want.steer_width)
                  report_mismatch("steer_width", got.steer_width, want.steer_width);
               if (got.speed_width !== want.speed_width)
                  report_mismatch("speed_width", got.speed_width, want.speed_width);
               if (got.buzzer_on !== want.buzzer_on)
                  report_mismatch("buzzer_on", got.buzzer_on, want.buzzer_on);
               if (got.announce !== want.announce)
                  report_mismatch("announce", got.announce, want.announce);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            t.pressure = req_bus.pressure_sample;
            t.front    = req_bus.front_echo;
            t.rear     = req_bus.rear_echo;
            t.cmd      = req_bus.cmd;
            want = advance_drive(t);
            if (pin_on) want = pin_want;
            pending_results.push_back(want);
         end
      end
   end

   function automatic int unsigned gap_length();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int unsigned sender_gap();
      if (quiet || hold_req || $urandom_range(0, 1) == 0) return 0;
      return gap_length();
   endfunction

   initial begin : rsp_side
      int unsigned n;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            n = gap_length();
            rsp_bus.ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   task automatic send_tick(input tick_type t, input bit pinned,
                            input drive_result_type want);
      @(negedge clock);
      req_bus.valid           <= 1'b1;
      req_bus.pressure_sample <= t.pressure;
      req_bus.front_echo      <= t.front;
      req_bus.rear_echo       <= t.rear;
      req_bus.cmd             <= t.cmd;
      pin_on                  <= pinned;
      pin_want                <= want;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic pause_sender(input int unsigned n);
      if (n > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [oidc_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [15:0] data);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         oidc_pkg::CSR_PRESSURE_LIMIT:     lim_pressure = data[11:0];
         oidc_pkg::CSR_DISTANCE_LIMIT:     lim_distance = data;
         oidc_pkg::CSR_SPEED_FAST_WIDTH:   w_fast = data;
         oidc_pkg::CSR_SPEED_SLOW_WIDTH:   w_slow = data;
         oidc_pkg::CSR_STEER_CENTER_WIDTH: w_center = data;
         oidc_pkg::CSR_STEER_RIGHT_WIDTH:  w_right = data;
         oidc_pkg::CSR_STEER_LEFT_WIDTH:   w_left = data;
         default: ;
      endcase
   endtask

   task automatic program_all(input logic [15:0] pressure, input logic [15:0] distance,
                              input logic [15:0] fast, input logic [15:0] slow,
                              input logic [15:0] center, input logic [15:0] right,
                              input logic [15:0] left);
      write_csr(oidc_pkg::CSR_PRESSURE_LIMIT, pressure);
      write_csr(oidc_pkg::CSR_DISTANCE_LIMIT, distance);
      write_csr(oidc_pkg::CSR_SPEED_FAST_WIDTH, fast);
      write_csr(oidc_pkg::CSR_SPEED_SLOW_WIDTH, slow);
      write_csr(oidc_pkg::CSR_STEER_CENTER_WIDTH, center);
      write_csr(oidc_pkg::CSR_STEER_RIGHT_WIDTH, right);
      write_csr(oidc_pkg::CSR_STEER_LEFT_WIDTH, left);
      write_csr(CSR_UNUSED, 16'($urandom));
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [15:0] pick_width();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_echo();
      int unsigned lim;
      lim = lim_distance;
      case ($urandom_range(0, 3))
         0:       return (lim == 0) ? 16'd0 : 16'($urandom_range(0, lim - 1));
         1:       return 16'($urandom_range(lim, 65535));
         2:       return 16'(lim + $urandom_range(0, 2) - 1);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic tick_type random_tick();
      tick_type    t;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6)
         t.pressure = (lim_pressure == 12'hfff) ? 12'hfff :
                      12'($urandom_range(int'(lim_pressure) + 1, 4095));
      else if (pick < 8)
         t.pressure = 12'($urandom_range(0, int'(lim_pressure)));
      else
         t.pressure = 12'($urandom);
      t.front = random_echo();
      t.rear  = random_echo();
      pick = $urandom_range(0, 19);
      if (pick < 17) t.cmd = DRIVE_CMDS[$urandom_range(0, 8)];
      else if (pick == 17) t.cmd = CMD_NONE;
      else t.cmd = 8'($urandom);
      return t;
   endfunction

   function automatic void row(logic [11:0] p, logic [15:0] f, logic [15:0] r, logic [7:0] c);
      stim_row_type s;
      s.t      = {p, f, r, c};
      s.pinned = 1'b0;
      s.want   = '0;
      stim_rows.push_back(s);
   endfunction

   function automatic void row_pinned(logic [11:0] p, logic [15:0] f, logic [15:0] r,
                                      logic [7:0] c, logic [1:0] pol, logic [1:0] dir,
                                      logic [15:0] steer, logic [15:0] speed,
                                      logic buz, logic ann);
      stim_row_type s;
      s.t      = {p, f, r, c};
      s.pinned = 1'b1;
      s.want   = {pol, dir, steer, speed, buz, ann};
      stim_rows.push_back(s);
   endfunction

   initial begin : stimulus
      int phase;
      int k;
      reset                   <= 1'b1;
      csr_wen                 <= 1'b0;
      csr_index               <= oidc_pkg::CSR_PRESSURE_LIMIT;
      csr_wdata               <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.pressure_sample <= '0;
      req_bus.front_echo      <= '0;
      req_bus.rear_echo       <= '0;
      req_bus.cmd             <= CMD_NONE;
      pin_on                  <= 1'b0;
      pin_want                <= '0;
      lim_pressure = oidc_pkg::PRESSURE_LIMIT_RST[11:0];
      lim_distance = oidc_pkg::DISTANCE_LIMIT_RST[15:0];
      w_fast       = FAST_RST;
      w_slow       = oidc_pkg::SPEED_SLOW_WIDTH_RST[15:0];
      w_center     = CENTER_RST;
      w_right      = oidc_pkg::STEER_RIGHT_WIDTH_RST[15:0];
      w_left       = oidc_pkg::STEER_LEFT_WIDTH_RST[15:0];
      pol_last     = oidc_pkg::POL_DEFAULT;
      dir_now      = oidc_pkg::DIR_STOP;
      steer_now    = CENTER_RST;
      speed_now    = FAST_RST;

      // reset values, threshold edges, forbidden moves, speed under stop, unknown codes
      row_pinned(12'd0, 16'd0, 16'd0, CMD_NONE,
                 oidc_pkg::POL_DEFAULT, oidc_pkg::DIR_STOP, CENTER_RST, FAST_RST,
                 1'b0, 1'b0);
      row_pinned(12'hfff, 16'd0, 16'd0, oidc_pkg::CMD_FWD_CENTER,
                 oidc_pkg::POL_STOP, oidc_pkg::DIR_STOP, CENTER_RST, FAST_RST,
                 1'b1, 1'b1);
      row_pinned(12'hfff, 16'd0, 16'd0, oidc_pkg::CMD_BWD_CENTER,
                 oidc_pkg::POL_STOP, oidc_pkg::DIR_STOP, CENTER_RST, FAST_RST,
                 1'b1, 1'b0);
      row_pinned(12'd600, 16'd0, 16'd0, oidc_pkg::CMD_FWD_CENTER,
                 oidc_pkg::POL_DEFAULT, oidc_pkg::DIR_FWD, CENTER_RST, FAST_RST,
                 1'b0, 1'b0);
      row_pinned(12'd601, 16'd4, 16'd5, oidc_pkg::CMD_FWD_LEFT,
                 oidc_pkg::POL_BWD, oidc_pkg::DIR_STOP, CENTER_RST, FAST_RST,
                 1'b1, 1'b1);
      row(12'd601, 16'd4, 16'hffff, oidc_pkg::CMD_BWD_LEFT);
      row(12'd601, 16'd5, 16'd4, oidc_pkg::CMD_FWD_RIGHT);
      row(12'd601, 16'hffff, 16'd4, oidc_pkg::CMD_BWD_RIGHT);
      row(12'd601, 16'hffff, 16'd0, oidc_pkg::CMD_SLOW);
      row(12'hfff, 16'd0, 16'd0, oidc_pkg::CMD_FAST);
      row(12'hfff, 16'd4, 16'd4, oidc_pkg::CMD_SLOW);
      row(12'd0, 16'd0, 16'd0, oidc_pkg::CMD_BWD_CENTER);
      row(12'd0, 16'd0, 16'd0, oidc_pkg::CMD_STOP);
      row(12'd0, 16'hffff, 16'hffff, oidc_pkg::CMD_BWD_RIGHT);
      row(12'd0, 16'd0, 16'd0, oidc_pkg::CMD_BWD_LEFT);
      row(12'd601, 16'hffff, 16'd4, oidc_pkg::CMD_FWD_LEFT);
      row(12'd0, 16'd0, 16'd0, oidc_pkg::CMD_FWD_RIGHT);
      row(12'd0, 16'd0, 16'd0, oidc_pkg::CMD_FWD_CENTER);
      row(12'd0, 16'd0, 16'd0, CMD_ALL_ONES);
      row(12'hfff, 16'hffff, 16'hffff, CMD_UPPER_W);
      row(12'hfff, 16'hffff, 16'hffff, CMD_ODD_LOW);
      row(12'd601, 16'd4, 16'd4, oidc_pkg::CMD_STOP);
      row(12'd601, 16'd4, 16'd4, CMD_HIGH_BIT);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         send_tick(stim_rows[i].t, stim_rows[i].pinned, stim_rows[i].want);
         pause_sender(sender_gap());
      end

      for (phase = 1; phase <= PHASES; phase++) begin
         drain();
         case (phase)
            1: ;
            2: program_all(16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                           16'h0000);
            3: program_all(16'hffff, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                           16'hffff);
            4: program_all(16'h0000, 16'h0000, pick_width(), pick_width(), pick_width(),
                           pick_width(), pick_width());
            default: program_all(pick_width(), pick_width(), pick_width(), pick_width(),
                                 pick_width(), pick_width(), pick_width());
         endcase
         quiet = (phase == 6);
         for (k = 0; k < PHASE_TICKS; k++) begin
            // long receiver stall while ticks keep coming
            if (phase == 5 && k == 40) hold_req = 1'b1;
            send_tick(random_tick(), 1'b0, '0);
            pause_sender(sender_gap());
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #LIMIT_NS;
      $display("TEST FAILED");
      $finish;
   end

endmodule
